// ===== hw/rtl/bez_pkg.sv =====
`timescale 1ns / 1ps

package bez_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PARAM_W   = FRAC_BITS + 1;
  localparam int AXES      = 3;
  localparam int HALF      = 1 << (FRAC_BITS - 1);

  typedef logic [PARAM_W-1:0] param_t;

  localparam param_t FRAC_ONE = param_t'(1 << FRAC_BITS);

endpackage

// ===== hw/rtl/bez_lerp.sv =====
`timescale 1ns / 1ps

module bez_lerp #(
  parameter int CW = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  bez_pkg::param_t       t,
  input  logic signed [CW-1:0]  a,
  input  logic signed [CW-1:0]  b,
  output logic signed [CW-1:0]  q
);

  localparam int PW = bez_pkg::PARAM_W + 1 + CW + 1;

  logic signed [CW:0]                   diff;
  logic signed [bez_pkg::PARAM_W:0]     t_s;
  logic signed [PW-1:0]                 prod;
  logic [PW-1:0]                        rnd;
  logic [CW-1:0]                        q_next;

  // a + ((t*(b-a) + half) >> 16), exact modulo 2^CW since the result is convex
  assign diff   = {b[CW-1], b} - {a[CW-1], a};
  assign t_s    = {1'b0, t};
  assign prod   = t_s * diff;
  assign rnd    = prod + PW'(bez_pkg::HALF);
  assign q_next = rnd[bez_pkg::FRAC_BITS +: CW] + a;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== hw/rtl/bezier_curve_point_eval_core.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake                 payload
// input     in   in_valid / in_ready       curve_param
// output    out  out_valid / out_ready     curve_x, curve_y, curve_z
// config    in   cfg_wr_en (no wait)       cfg_index, cfg_data
//
// one request per cycle sustained while out_ready stays high
// (the first register stage captures the saturated t, then one lerp level per register stage)
// rst clears the valid bits and the control point registers
// each stage holds while the next is full and stalled; empty stages still fill

module bezier_curve_point_eval_core #(
  parameter int NUM_POINTS  = 5,
  parameter int COORD_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [$clog2(NUM_POINTS)-1:0]      cfg_index,
  input  logic [3*COORD_WIDTH-1:0]           cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bez_pkg::param_t                    curve_param,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [COORD_WIDTH-1:0]      curve_x,
  output logic signed [COORD_WIDTH-1:0]      curve_y,
  output logic signed [COORD_WIDTH-1:0]      curve_z
);

  localparam int N     = NUM_POINTS;
  localparam int CW    = COORD_WIDTH;
  localparam int IDX_W = $clog2(NUM_POINTS);

  logic [bez_pkg::AXES*CW-1:0]  point_regs [N];
  logic signed [CW-1:0]         coord      [N][bez_pkg::AXES];

  bez_pkg::param_t              tq  [N-1];
  logic [N-1:0]                 vld;
  logic [N:0]                   rdy;
  logic signed [CW-1:0]         pt  [N-1][N-1][bez_pkg::AXES];
  bez_pkg::param_t              t_sat;

  // control points
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        point_regs[k] <= '0;
      end
    end else if (cfg_wr_en && ({1'b0, cfg_index} < (IDX_W+1)'(N))) begin
      point_regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      for (int ax = 0; ax < bez_pkg::AXES; ax++) begin
        coord[k][ax] = point_regs[k][ax*CW +: CW];
      end
    end
  end

  // stage enables
  always_comb begin
    rdy[N] = out_ready;
    for (int g = N - 1; g >= 0; g--) begin
      rdy[g] = !vld[g] || rdy[g+1];
    end
  end

  assign in_ready = rdy[0];
  assign t_sat    = curve_param[bez_pkg::FRAC_BITS] ? bez_pkg::FRAC_ONE : curve_param;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int g = 1; g < N; g++) begin
        if (rdy[g]) begin
          vld[g] <= vld[g-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      tq[0] <= t_sat;
    end
    for (int g = 1; g < N - 1; g++) begin
      if (rdy[g]) begin
        tq[g] <= tq[g-1];
      end
    end
  end

  // lerp levels
  for (genvar g = 1; g < N; g++) begin : g_level
    for (genvar k = 0; k < N - g; k++) begin : g_lane
      for (genvar ax = 0; ax < bez_pkg::AXES; ax++) begin : g_axis
        logic signed [CW-1:0] a_in;
        logic signed [CW-1:0] b_in;
        if (g == 1) begin : g_first
          assign a_in = coord[k][ax];
          assign b_in = coord[k+1][ax];
        end else begin : g_rest
          assign a_in = pt[g-2][k][ax];
          assign b_in = pt[g-2][k+1][ax];
        end
        bez_lerp #(
          .CW (CW)
        ) u_lerp (
          .clk (clk),
          .en  (rdy[g]),
          .t   (tq[g-1]),
          .a   (a_in),
          .b   (b_in),
          .q   (pt[g-1][k][ax])
        );
      end
    end
  end

  assign out_valid = vld[N-1];
  assign curve_x   = pt[N-2][0][0];
  assign curve_y   = pt[N-2][0][1];
  assign curve_z   = pt[N-2][0][2];

`ifndef SYNTH
  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !out_ready |-> !in_ready)
    else $error("input accepted into a full stalled pipeline");

  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted request not captured in first stage");

  a_param_saturates: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && curve_param[bez_pkg::FRAC_BITS] |=> tq[0] == bez_pkg::FRAC_ONE)
    else $error("curve parameter above one not saturated");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_PTS = 5;
  localparam int COORD_W = 16;
  localparam int IDX_W = $clog2(NUM_PTS);
  localparam int IDX_TOP = (1 << IDX_W) - 1;
  localparam int REG_POINT0 = 0;
  localparam int REG_POINT4 = 4;
  localparam int LATENCY = NUM_PTS;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_ITEMS = 205;
  localparam logic [COORD_W-1:0] COORD_MAX = 16'h7fff;
  localparam logic [COORD_W-1:0] COORD_MIN = 16'h8000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [3*COORD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  bez_pkg::param_t curve_param = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] curve_x;
  logic signed [COORD_W-1:0] curve_y;
  logic signed [COORD_W-1:0] curve_z;

  logic [3*COORD_W-1:0] point_regs [NUM_PTS];
  bez_pkg::param_t param_queue [$];
  point_t expected_points [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit stall_armed = 1'b0;
  bit stall_done = 1'b0;

  bezier_curve_point_eval_core #(
    .NUM_POINTS (NUM_PTS),
    .COORD_WIDTH(COORD_W)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .curve_param(curve_param),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .curve_x    (curve_x),
    .curve_y    (curve_y),
    .curve_z    (curve_z)
  );

  always #6 clk = ~clk;

  function automatic longint coord_of(input logic [3*COORD_W-1:0] packed_pt, input int axis);
    logic signed [COORD_W-1:0] c;
    c = packed_pt[axis*COORD_W +: COORD_W];
    return longint'(c);
  endfunction

  // de casteljau pyramid with round-to-nearest lerps
  function automatic point_t curve_point(input bez_pkg::param_t tp);
    longint t;
    longint pyr [NUM_PTS][3];
    point_t p;
    t = (tp > bez_pkg::FRAC_ONE) ? longint'(bez_pkg::FRAC_ONE) : longint'(tp);
    for (int k = 0; k < NUM_PTS; k++)
      for (int ax = 0; ax < 3; ax++)
        pyr[k][ax] = coord_of(point_regs[k], ax);
    for (int lvl = 1; lvl < NUM_PTS; lvl++)
      for (int k = 0; k < NUM_PTS - lvl; k++)
        for (int ax = 0; ax < 3; ax++)
          pyr[k][ax] = (t * pyr[k+1][ax] + (longint'(bez_pkg::FRAC_ONE) - t) * pyr[k][ax]
                        + bez_pkg::HALF) >>> bez_pkg::FRAC_BITS;
    p.x = pyr[0][0][COORD_W-1:0];
    p.y = pyr[0][1][COORD_W-1:0];
    p.z = pyr[0][2][COORD_W-1:0];
    return p;
  endfunction

  task automatic check_coord(input string name, input logic [COORD_W-1:0] exp_v,
                             input logic [COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %0d got %0d", $time, name,
               $signed(exp_v), $signed(act_v));
      errors++;
    end
  endtask

  task automatic queue_param(input bez_pkg::param_t p);
    param_queue.insert(param_queue.size(), p);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_points.insert(expected_points.size(), curve_point(curve_param));
      if (!in_valid || in_ready) begin
        if (param_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          curve_param <= param_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      stall_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t unexpected result: expected none got %0d %0d %0d", $time,
                   curve_x, curve_y, curve_z);
          errors++;
        end else begin
          want = expected_points.pop_front();
          check_coord("curve_x", want.x, curve_x);
          check_coord("curve_y", want.y, curve_y);
          check_coord("curve_z", want.z, curve_z);
        end
      end
      if (stall_armed && !stall_done) begin
        stall_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (param_queue.size() == 0 && !in_valid && expected_points.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_point(input int idx, input logic [3*COORD_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx[IDX_W-1:0];
    cfg_data <= data;
    if (idx < NUM_PTS)
      point_regs[idx] = data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(5))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic bez_pkg::param_t rand_param();
    case ($urandom_range(9))
      0: return '0;
      1: return bez_pkg::FRAC_ONE;
      2, 3: return bez_pkg::param_t'($urandom_range((2 ** bez_pkg::PARAM_W) - 1));
      default: return bez_pkg::param_t'($urandom_range(bez_pkg::FRAC_ONE));
    endcase
  endfunction

  task automatic reconfigure_random();
    for (int k = REG_POINT0; k <= REG_POINT4; k++)
      write_point(k, {rand_coord(), rand_coord(), rand_coord()});
    write_point($urandom_range(IDX_TOP, NUM_PTS), (3*COORD_W)'({$urandom, $urandom}));
  endtask

  // wait for the pipeline to empty
  task automatic drain();
    while (param_queue.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  initial begin
    bez_pkg::param_t sweep_a [10];
    bez_pkg::param_t sweep_b [8];
    for (int k = 0; k < NUM_PTS; k++)
      point_regs[k] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // control points still at reset
    queue_param('0);
    queue_param(bez_pkg::FRAC_ONE);
    queue_param(bez_pkg::param_t'(17'h1ffff));
    drain();

    // alternating extreme control points
    for (int k = REG_POINT0; k <= REG_POINT4; k++)
      write_point(k, (k % 2 == 0) ? {3{COORD_MAX}} : {3{COORD_MIN}});
    sweep_a = '{17'h00000, 17'h00001, 17'h08000, 17'h0ffff, 17'h10000,
                17'h10001, 17'h1ffff, 17'h04000, 17'h0c000, 17'h07fff};
    foreach (sweep_a[i])
      queue_param(sweep_a[i]);
    drain();

    // mixed points, then writes to missing indexes must be ignored
    for (int k = REG_POINT0; k <= REG_POINT4; k++)
      write_point(k, {rand_coord(), rand_coord(), rand_coord()});
    for (int idx = NUM_PTS; idx <= IDX_TOP; idx++)
      write_point(idx, '1);
    sweep_b = '{17'h00000, 17'h10000, 17'h186a0, 17'h03039, 17'h11170,
                17'h0aaaa, 17'h15555, 17'h0ffff};
    foreach (sweep_b[i])
      queue_param(sweep_b[i]);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 57 : 0;
      recv_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 26 : 0;
      for (int sub = 0; sub < 2; sub++) begin
        reconfigure_random();
        if (mode == 2 && sub == 0)
          stall_armed = 1'b1;
        for (int n = 0; n < PHASE_ITEMS; n++)
          queue_param(rand_param());
        drain();
      end
    end

    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== bezier_curve_point_eval_core.f =====
hw/rtl/bez_pkg.sv
hw/rtl/bez_lerp.sv
hw/rtl/bezier_curve_point_eval_core.sv
tb/testbench.sv
